### hw/rtl/average_pool_hwc_int8_defines.svh
// ----------------------------------------------------------------------------
// Average pool assertion macros
// Shared property shorthands for the pooling block's RTL checks.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_POOL_HWC_INT8_DEFINES_SVH
`define AVERAGE_POOL_HWC_INT8_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define APOOL_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define APOOL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/apool_pkg.sv
// ----------------------------------------------------------------------------
// Average pool package
// Widths, codes and shared types of the int8 HWC average pooling block.
// ----------------------------------------------------------------------------
package apool_pkg;

    // sample store
    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
    localparam int unsigned PAD_X       = 0;
    localparam int unsigned PAD_Y       = 0;

    // field widths
    localparam int unsigned CFG_W    = 7;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned SADDR_W  = 12;
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned COUNT_W  = 13;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // datapath widths
    localparam int unsigned CNT_W   = 2 * CFG_W;             // clipped window size
    localparam int unsigned PIX_W   = 2 * CFG_W + 1;         // pixel index
    localparam int unsigned WIN_AW  = CFG_W + PIX_W;         // window sample address
    localparam int unsigned SUM_W   = CNT_W + SAMPLE_W;      // signed window sum
    localparam int unsigned DIVD_W  = SUM_W + (2 ** SHIFT_W) - 1;
    localparam int unsigned DCNT_W  = $clog2(DIVD_W);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // command queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_IN_WIDTH      = 3'd0,
        REG_IN_HEIGHT     = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_WINDOW_WIDTH  = 3'd3,
        REG_WINDOW_HEIGHT = 3'd4,
        REG_COL_STRIDE    = 3'd5,
        REG_ROW_STRIDE    = 3'd6,
        REG_SCALE_SHIFT   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]   in_width;
        logic [CFG_W-1:0]   in_height;
        logic [CFG_W-1:0]   channel_count;
        logic [CFG_W-1:0]   window_width;
        logic [CFG_W-1:0]   window_height;
        logic [CFG_W-1:0]   col_stride;
        logic [CFG_W-1:0]   row_stride;
        logic [SHIFT_W-1:0] scale_shift;
    } apool_cfg_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t                       op;
        logic [SADDR_W-1:0]        sample_addr;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [POS_W-1:0]          channel;
        logic [CFG_W-1:0]          x_lo;
        logic [CFG_W-1:0]          x_span;
        logic [CFG_W-1:0]          y_lo;
        logic [CFG_W-1:0]          y_span;
    } apool_cmd_t;

endpackage

### hw/rtl/average_pool_hwc_int8.sv
// ----------------------------------------------------------------------------
// Int8 HWC average pool
// Top level: configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per item. s_tuser is the op (0 load, 1 query).
//   A load writes sample_value into the sample store and returns nothing; a
//   query returns one m_* transaction with the pooled value of one window.
//   cfg_* channel: register writes, always ready; write only while idle.
// Flow:
//   A load passes the front register and the command queue before it reaches
//   the store; the back end takes one load per cycle while it is idle.
//   A query reads its N samples, N being the clipped window size: one store
//   read per cycle, then a radix-2 divider. Queries execute one at a time;
//   an empty window skips the walk and the divider.
//   A 4-entry queue keeps the input open.
// Reset: aresetn (synchronous) clears control and loads register defaults.
//   Store contents are undefined until written; there is no clearing pass.
// Stall: a held m_tready keeps the result in the output register, the back
//   end stops after the next result, then the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module average_pool_hwc_int8 (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [11:0] sample_addr, [19:12] sample_value, [25:20] out_col,
    // [31:26] out_row, [37:32] out_channel, [39:38] zero
    input  logic [apool_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,    // [0] op
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] pooled_value, [20:8] window_count, [23:21] zero
    output logic [apool_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,    // [0] empty_window
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [apool_pkg::IDX_W-1:0]         cfg_index,
    input  logic [apool_pkg::CFG_W-1:0]         cfg_data
);
    import apool_pkg::*;

    apool_cfg_t cfg_reg;
    apool_cfg_t cfg_next;

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    apool_cmd_t q_in;
    apool_cmd_t q_out;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IN_WIDTH:      cfg_next.in_width      = cfg_data;
                REG_IN_HEIGHT:     cfg_next.in_height     = cfg_data;
                REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_data;
                REG_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data;
                REG_WINDOW_HEIGHT: cfg_next.window_height = cfg_data;
                REG_COL_STRIDE:    cfg_next.col_stride    = cfg_data;
                REG_ROW_STRIDE:    cfg_next.row_stride    = cfg_data;
                REG_SCALE_SHIFT:   cfg_next.scale_shift   = cfg_data[SHIFT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_width      <= CFG_W'(1);
            cfg_reg.in_height     <= CFG_W'(1);
            cfg_reg.channel_count <= CFG_W'(1);
            cfg_reg.window_width  <= CFG_W'(1);
            cfg_reg.window_height <= CFG_W'(1);
            cfg_reg.col_stride    <= CFG_W'(1);
            cfg_reg.row_stride    <= CFG_W'(1);
            cfg_reg.scale_shift   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    apool_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    apool_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    apool_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_cmd    (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### hw/rtl/apool_fifo.sv
// ----------------------------------------------------------------------------
// Average pool command queue
// Small register FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "average_pool_hwc_int8_defines.svh"

module apool_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  apool_pkg::apool_cmd_t push_data,
    input  logic                  pop,
    output apool_pkg::apool_cmd_t pop_data,
    output logic                  full,
    output logic                  empty
);
    import apool_pkg::*;

    apool_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;

    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `APOOL_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full, "push into full queue")
    `APOOL_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, !empty, "pop from empty queue")
    `APOOL_ASSERT_NEXT(a_push_fills, aclk, aresetn, push && !pop, !empty, "queue lost an entry")

endmodule

### hw/rtl/apool_div.sv
// ----------------------------------------------------------------------------
// Average pool divider
// Radix-2 restoring divider: signed sum by unsigned count, truncating to zero.
// ----------------------------------------------------------------------------
module apool_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [apool_pkg::DIVD_W-1:0]         dividend,
    input  logic [apool_pkg::CNT_W-1:0]          divisor,
    output logic                                 done,
    output logic [apool_pkg::SAMPLE_W-1:0]       quotient
);
    import apool_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DCNT_W-1:0]   step_reg;
    logic                neg_reg;
    logic [DIVD_W-1:0]   num_reg;    // magnitude, shifts out as quotient bits shift in
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    den_reg;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                q_bit;

    assign trial = {rem_reg, num_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign q_bit = (trial >= {1'b0, den_reg});

    assign done     = done_reg;
    // low bits of the negated magnitude equal the negation of the low bits
    assign quotient = neg_reg ? (~num_reg[SAMPLE_W-1:0] + 1'b1) : num_reg[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (step_reg == DCNT_W'(DIVD_W-1))) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= dividend[DIVD_W-1];
            num_reg  <= dividend[DIVD_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
            step_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            num_reg  <= {num_reg[DIVD_W-2:0], q_bit};
            step_reg <= step_reg + 1'b1;
        end
    end

endmodule

### hw/rtl/apool_front.sv
// ----------------------------------------------------------------------------
// Average pool front end
// Registers input transactions, clips query windows to the image and queues them.
// ----------------------------------------------------------------------------
module apool_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  apool_pkg::apool_cfg_t               cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [apool_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    input  logic                                q_full,
    output logic                                q_push,
    output apool_pkg::apool_cmd_t               q_cmd
);
    import apool_pkg::*;

    // returns {lo, span} of [pos*step - pad, +len) clipped to [0, limit)
    function automatic logic [2*CFG_W-1:0] clip_span(
        input logic [POS_W-1:0] pos,
        input logic [CFG_W-1:0] step,
        input logic [CFG_W-1:0] len,
        input logic [CFG_W-1:0] limit,
        input logic [POS_W-1:0] pad
    );
        logic [12:0]        prod;
        logic signed [14:0] a;
        logic signed [14:0] b;
        logic signed [14:0] lim;
        logic signed [14:0] lo;
        logic signed [14:0] hi;
        logic signed [14:0] span;
        prod = 13'(pos) * 13'(step);
        a    = signed'({2'b00, prod}) - signed'(15'(pad));
        b    = a + signed'(15'(len));
        lim  = signed'(15'(limit));
        lo   = (a < 15'sd0) ? 15'sd0 : a;
        hi   = (b > lim) ? lim : b;
        span = (hi > lo) ? (hi - lo) : 15'sd0;
        return {lo[CFG_W-1:0], span[CFG_W-1:0]};
    endfunction

    logic                       valid_reg;
    op_t                        op_reg;
    logic [SADDR_W-1:0]         addr_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic [POS_W-1:0]           col_reg;
    logic [POS_W-1:0]           row_reg;
    logic [POS_W-1:0]           chan_reg;

    logic [2*CFG_W-1:0]         x_clip;
    logic [2*CFG_W-1:0]         y_clip;
    logic                       s_accept;

    assign s_tready = !valid_reg || !q_full;
    assign s_accept = s_tvalid && s_tready;
    assign q_push   = valid_reg && !q_full;

    assign x_clip = clip_span(col_reg, cfg.col_stride, cfg.window_width, cfg.in_width,
                              POS_W'(PAD_X));
    assign y_clip = clip_span(row_reg, cfg.row_stride, cfg.window_height, cfg.in_height,
                              POS_W'(PAD_Y));

    always_comb begin
        q_cmd.op           = op_reg;
        q_cmd.sample_addr  = addr_reg;
        q_cmd.sample_value = value_reg;
        q_cmd.channel      = chan_reg;
        q_cmd.x_lo         = x_clip[2*CFG_W-1:CFG_W];
        q_cmd.x_span       = x_clip[CFG_W-1:0];
        q_cmd.y_lo         = y_clip[2*CFG_W-1:CFG_W];
        q_cmd.y_span       = y_clip[CFG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_accept) begin
            valid_reg <= 1'b1;
        end else if (q_push) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg    <= op_t'(s_tuser);
            addr_reg  <= s_tdata[11:0];
            value_reg <= s_tdata[19:12];
            col_reg   <= s_tdata[25:20];
            row_reg   <= s_tdata[31:26];
            chan_reg  <= s_tdata[37:32];
        end
    end

endmodule

### hw/rtl/apool_back.sv
// ----------------------------------------------------------------------------
// Average pool back end
// Owns the sample store; executes loads and walks query windows, then divides.
// ----------------------------------------------------------------------------
`include "average_pool_hwc_int8_defines.svh"

module apool_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  apool_pkg::apool_cfg_t               cfg,
    input  logic                                q_empty,
    input  apool_pkg::apool_cmd_t               q_cmd,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [apool_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser
);
    import apool_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_BASE   = 8'b0000_0100,
        S_WALK   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_DIV_GO = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    localparam logic [WIN_AW-1:0] STORE_LIMIT = WIN_AW'(STORE_DEPTH);

    state_t                 state_reg;
    state_t                 state_next;

    logic [POS_W-1:0]       chan_reg;
    logic [CFG_W-1:0]       x_lo_reg;
    logic [CFG_W-1:0]       x_span_reg;
    logic [CFG_W-1:0]       y_lo_reg;
    logic [CFG_W-1:0]       y_span_reg;
    logic [PIX_W-1:0]       row_pix_reg;
    logic [CNT_W-1:0]       row_step_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   empty_reg;
    logic [WIN_AW-1:0]      row_addr_reg;
    logic [WIN_AW-1:0]      addr_reg;
    logic [CFG_W-1:0]       x_cnt_reg;
    logic [CFG_W-1:0]       y_cnt_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic [SAMPLE_W-1:0]    store_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0]    rd_data_reg;
    logic                   rd_inrange_reg;
    logic                   rd_valid_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    pooled_reg;
    logic [COUNT_W-1:0]     wcount_reg;
    logic                   wempty_reg;

    logic                   load_go;
    logic [WIN_AW-1:0]      wr_addr_ext;
    logic                   wr_en;
    logic                   issue;
    logic                   x_last;
    logic                   y_last;
    logic [PIX_W-1:0]       pix;
    logic [WIN_AW-1:0]      base_addr;
    logic [DIVD_W-1:0]      dividend;
    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_W-1:0]    div_quot;
    logic                   out_free;
    logic                   out_load;

    assign q_pop       = (state_reg == S_IDLE) && !q_empty;
    assign load_go     = q_pop && (q_cmd.op == OP_LOAD);
    assign wr_addr_ext = WIN_AW'(q_cmd.sample_addr);
    assign wr_en       = load_go && (wr_addr_ext < STORE_LIMIT);

    assign issue  = (state_reg == S_WALK);
    assign x_last = ((x_cnt_reg + 1'b1) == x_span_reg);
    assign y_last = ((y_cnt_reg + 1'b1) == y_span_reg);

    assign pix       = row_pix_reg + PIX_W'(x_lo_reg);
    assign base_addr = WIN_AW'(chan_reg) + WIN_AW'(cfg.channel_count) * WIN_AW'(pix);

    assign dividend  = {{(DIVD_W-SUM_W){acc_reg[SUM_W-1]}}, acc_reg} << cfg.scale_shift;
    assign div_start = (state_reg == S_DIV_GO);

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == S_FIN) && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-COUNT_W-SAMPLE_W)'(0), wcount_reg, pooled_reg};
    assign m_tuser  = wempty_reg;

    apool_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_pop && (q_cmd.op == OP_QUERY)) state_next = S_SETUP;
            end
            S_SETUP: begin
                if ((x_span_reg == '0) || (y_span_reg == '0)) state_next = S_FIN;
                else state_next = S_BASE;
            end
            S_BASE:   state_next = S_WALK;
            S_WALK: begin
                if (x_last && y_last) state_next = S_DRAIN;
            end
            S_DRAIN:  state_next = S_DIV_GO;    // last sample lands in acc here
            S_DIV_GO: state_next = S_DIV;
            S_DIV: begin
                if (div_done) state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr_ext[STORE_AW-1:0]] <= q_cmd.sample_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg    <= store_mem[addr_reg[STORE_AW-1:0]];
            rd_inrange_reg <= (addr_reg < STORE_LIMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            chan_reg   <= q_cmd.channel;
            x_lo_reg   <= q_cmd.x_lo;
            x_span_reg <= q_cmd.x_span;
            y_lo_reg   <= q_cmd.y_lo;
            y_span_reg <= q_cmd.y_span;
        end

        case (state_reg)
            S_SETUP: begin
                row_pix_reg  <= PIX_W'(y_lo_reg) * PIX_W'(cfg.in_width);
                row_step_reg <= CNT_W'(cfg.channel_count) * CNT_W'(cfg.in_width);
                count_reg    <= CNT_W'(x_span_reg) * CNT_W'(y_span_reg);
                empty_reg    <= (x_span_reg == '0) || (y_span_reg == '0);
            end
            S_BASE: begin
                addr_reg     <= base_addr;
                row_addr_reg <= base_addr;
                x_cnt_reg    <= '0;
                y_cnt_reg    <= '0;
            end
            S_WALK: begin
                if (x_last) begin
                    x_cnt_reg    <= '0;
                    y_cnt_reg    <= y_cnt_reg + 1'b1;
                    row_addr_reg <= row_addr_reg + WIN_AW'(row_step_reg);
                    addr_reg     <= row_addr_reg + WIN_AW'(row_step_reg);
                end else begin
                    x_cnt_reg <= x_cnt_reg + 1'b1;
                    addr_reg  <= addr_reg + WIN_AW'(cfg.channel_count);
                end
            end
            default: begin
            end
        endcase

        // samples past the end of the store count but add zero
        if (state_reg == S_BASE) begin
            acc_reg <= '0;
        end else if (rd_valid_reg && rd_inrange_reg) begin
            acc_reg <= acc_reg + {{(SUM_W-SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg};
        end

        if (out_load) begin
            wempty_reg <= empty_reg;
            if (empty_reg) begin
                pooled_reg <= '0;
                wcount_reg <= '0;
            end else begin
                pooled_reg <= div_quot;
                wcount_reg <= (count_reg > CNT_W'(COUNT_MAX)) ? COUNT_MAX
                                                              : count_reg[COUNT_W-1:0];
            end
        end
    end

    `APOOL_ASSERT_IMPL(a_read_in_walk, aclk, aresetn, rd_valid_reg, (state_reg == S_WALK) || (state_reg == S_DRAIN), "store read data outside window walk")
    `APOOL_ASSERT_IMPL(a_div_done_waited, aclk, aresetn, div_done, state_reg == S_DIV, "divider finished while not awaited")
    `APOOL_ASSERT_NEXT(a_result_posted, aclk, aresetn, out_load, out_valid_reg, "finished result not presented")

endmodule

### dv/average_pool_hwc_int8_test.sv
// ----------------------------------------------------------------------------
// Int8 HWC average pool testbench
// Loads samples into the pooling block's store and queries pooled windows over
// a range of image, window, stride and scale settings. A local predictor keeps
// its own copy of the store and registers and checks every result in order.
// ----------------------------------------------------------------------------
module average_pool_hwc_int8_test;
    timeunit 1ns;
    timeprecision 1ps;

    import apool_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned LOAD_SETTLE  = 8;     // loads in flight after last result
    localparam int unsigned DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pooled;
        logic [COUNT_W-1:0]         count;
        logic                       empty;
    } pool_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // predictor state
    apool_cfg_t                 pool_cfg;
    logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
    logic                       sample_written [STORE_DEPTH];
    int unsigned                fill_addrs [$];
    pool_result_t               expected_pools [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned loads_sent    = 0;
    int unsigned queries_sent  = 0;
    int unsigned results_seen  = 0;
    int unsigned empty_seen    = 0;
    int unsigned reg_writes    = 0;

    average_pool_hwc_int8 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pools.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", field, got, want, $time);
        error_count++;
    endtask

    // Clip the window to the image, sum the samples, scale and divide. Store entries
    // not yet loaded are collected in fill_addrs.
    function automatic pool_result_t predict_pool(input logic [POS_W-1:0] col, row, ch);
        pool_result_t     res;
        int               x_lo, x_hi, y_lo, y_hi;
        int unsigned      n;
        longint           acc;
        longint           quot;
        longint unsigned  addr;
        x_lo = int'(col) * int'(pool_cfg.col_stride) - int'(PAD_X);
        y_lo = int'(row) * int'(pool_cfg.row_stride) - int'(PAD_Y);
        x_hi = x_lo + int'(pool_cfg.window_width);
        y_hi = y_lo + int'(pool_cfg.window_height);
        if (x_lo < 0) x_lo = 0;
        if (y_lo < 0) y_lo = 0;
        if (x_hi > int'(pool_cfg.in_width)) x_hi = int'(pool_cfg.in_width);
        if (y_hi > int'(pool_cfg.in_height)) y_hi = int'(pool_cfg.in_height);
        if (x_hi < x_lo) x_hi = x_lo;
        if (y_hi < y_lo) y_hi = y_lo;
        n = (x_hi - x_lo) * (y_hi - y_lo);
        acc = 0;
        for (int y = y_lo; y < y_hi; y++) begin
            for (int x = x_lo; x < x_hi; x++) begin
                addr = longint'(ch) + longint'(pool_cfg.channel_count) *
                       (longint'(x) + longint'(y) * longint'(pool_cfg.in_width));
                // samples past the end of the store read as zero but still count
                if (addr < STORE_DEPTH) begin
                    if (!sample_written[addr]) fill_addrs.push_back(int'(addr));
                    acc += sample_mem[addr];
                end
            end
        end
        if (n == 0) begin
            res = '{pooled: '0, count: '0, empty: 1'b1};
        end else begin
            quot = (acc * (longint'(1) << pool_cfg.scale_shift)) / longint'(n);
            res.pooled = quot[SAMPLE_W-1:0];
            res.count  = (n > COUNT_MAX) ? COUNT_MAX : n[COUNT_W-1:0];
            res.empty  = 1'b0;
        end
        return res;
    endfunction

    task automatic send_item(input op_t op, input logic [SADDR_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] value,
                             input logic [POS_W-1:0] col, row, ch);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, ch, row, col, value, addr};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_LOAD) begin
            if (addr < STORE_DEPTH) begin
                sample_mem[addr]     = value;
                sample_written[addr] = 1'b1;
            end
            loads_sent++;
        end else begin
            expected_pools.push_back(predict_pool(col, row, ch));
            queries_sent++;
        end
    endtask

    task automatic send_load(input logic [SADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] value);
        send_item(OP_LOAD, addr, value, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
    endtask

    // loads whatever the window reads that was never written, then queries it
    task automatic send_query(input logic [POS_W-1:0] col, row, ch);
        fill_addrs.delete();
        void'(predict_pool(col, row, ch));
        foreach (fill_addrs[i]) begin
            if (!sample_written[fill_addrs[i]]) begin
                send_load(SADDR_W'(fill_addrs[i]), SAMPLE_W'($urandom));
            end
        end
        send_item(OP_QUERY, SADDR_W'($urandom), SAMPLE_W'($urandom), col, row, ch);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_pools.size() != 0) @(posedge aclk);
        repeat (LOAD_SETTLE) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] w, h, cc, ww, wh, sx, sy, sh);
        logic [CFG_W-1:0] vals [8];
        cfg_idx_t         idx;
        settle();
        vals = '{w, h, cc, ww, wh, sx, sy, sh};
        for (int i = 0; i < 8; i++) begin
            idx = cfg_idx_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx)
                REG_IN_WIDTH:      pool_cfg.in_width      = vals[i];
                REG_IN_HEIGHT:     pool_cfg.in_height     = vals[i];
                REG_CHANNEL_COUNT: pool_cfg.channel_count = vals[i];
                REG_WINDOW_WIDTH:  pool_cfg.window_width  = vals[i];
                REG_WINDOW_HEIGHT: pool_cfg.window_height = vals[i];
                REG_COL_STRIDE:    pool_cfg.col_stride    = vals[i];
                REG_ROW_STRIDE:    pool_cfg.row_stride    = vals[i];
                REG_SCALE_SHIFT:   pool_cfg.scale_shift   = vals[i][SHIFT_W-1:0];
                default: ;
            endcase
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : check_results
        pool_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_pools.size() == 0) begin
                report_mismatch("unexpected result", {m_tuser, m_tdata}, '0);
            end else begin
                want = expected_pools.pop_front();
                if (want.empty) empty_seen++;
                if (m_tdata[7:0] !== want.pooled)
                    report_mismatch("pooled_value", m_tdata[7:0], want.pooled);
                if (m_tdata[20:8] !== want.count)
                    report_mismatch("window_count", m_tdata[20:8], want.count);
                if (m_tuser !== want.empty)
                    report_mismatch("empty_window", m_tuser, want.empty);
            end
        end
    end

    // register defaults: 1x1 image, one channel, 1x1 window
    task automatic test_reset_defaults();
        send_load('0, 8'sh80);
        send_load(SADDR_W'(STORE_DEPTH - 1), 8'sh7f);
        send_query(0, 0, 0);
        send_query(1, 0, 0);
        send_query(0, 0, 1);
    endtask

    // 3x2 image, two channels, 2x2 window, stride 2
    task automatic test_clipped_windows();
        logic signed [SAMPLE_W-1:0] pattern [12];
        pattern = '{127, -1, 127, -2, -128, -3, 127, -1, -128, -128, -1, -128};
        program_regs(3, 2, 2, 2, 2, 2, 2, 0);
        foreach (pattern[i]) send_load(SADDR_W'(i), pattern[i]);
        send_query(0, 0, 0);        // full window
        send_query(1, 0, 1);        // clipped on the right, negative sum truncates
        send_query(0, 1, 0);        // starts below the image
        send_query(63, 63, 63);     // far outside
        send_query(0, 0, 5);        // channel beyond channel_count
    endtask

    task automatic test_scale_and_wrap();
        program_regs(3, 2, 2, 2, 2, 2, 2, 7'h7f);   // upper bits of shift ignored
        send_query(0, 0, 0);
        send_query(0, 0, 1);
        program_regs(3, 2, 2, 2, 2, 2, 2, 7'h7c);
        send_query(0, 0, 0);
        send_query(1, 0, 1);
    endtask

    task automatic test_degenerate_regs();
        program_regs(3, 2, 2, 0, 2, 1, 1, 0);       // zero window width
        send_query(0, 0, 0);
        program_regs(3, 0, 2, 2, 2, 1, 1, 0);       // zero image height
        send_query(0, 0, 1);
        program_regs(3, 2, 2, 2, 2, 0, 0, 1);       // zero strides pin the window
        send_query(63, 63, 1);
        program_regs(3, 2, 0, 2, 2, 1, 1, 0);       // zero channels: every tap same address
        send_query(0, 0, 3);
    endtask

    task automatic test_large_windows();
        program_regs(64, 64, 64, 64, 64, 1, 1, 3);  // most taps fall past the store
        send_query(0, 0, 63);
        program_regs(127, 127, 127, 127, 127, 127, 127, 0);
        send_query(0, 0, 0);                        // count saturates
        send_query(63, 63, 0);
    endtask

    task automatic test_random_traffic(input int unsigned per_batch);
        int unsigned pick;
        int unsigned w, h, cc, sx, sy;
        for (int b = 0; b < 3; b++) begin
            program_regs(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
                         CFG_W'($urandom_range(1, 4)),
                         CFG_W'($urandom_range(1, 4)), CFG_W'($urandom_range(1, 4)),
                         CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 3)),
                         CFG_W'($urandom_range(0, 7)));
            w  = pool_cfg.in_width;
            h  = pool_cfg.in_height;
            cc = pool_cfg.channel_count;
            sx = pool_cfg.col_stride;
            sy = pool_cfg.row_stride;
            for (int n = 0; n < per_batch; n++) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    send_query(POS_W'((sx == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, (w - 1) / sx)),
                               POS_W'((sy == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, (h - 1) / sy)),
                               POS_W'($urandom_range(0, cc - 1)));
                end else if (pick < 78) begin
                    send_load(SADDR_W'($urandom_range(0, cc - 1) +
                              cc * ($urandom_range(0, w - 1) + $urandom_range(0, h - 1) * w)),
                              SAMPLE_W'($urandom));
                end else if (pick < 90) begin
                    send_load(SADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                              SAMPLE_W'($urandom));
                end else begin
                    send_query(POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                               POS_W'($urandom_range(0, 63)));
                end
            end
        end
    endtask

    initial begin
        pool_cfg = '{in_width: 1, in_height: 1, channel_count: 1, window_width: 1,
                     window_height: 1, col_stride: 1, row_stride: 1, scale_shift: 0};
        foreach (sample_written[i]) begin
            sample_written[i] = 1'b0;
            sample_mem[i]     = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 80;
        test_reset_defaults();
        test_clipped_windows();
        test_scale_and_wrap();
        test_degenerate_regs();
        test_large_windows();
        test_random_traffic(25);

        send_idle_pct = 80;
        recv_idle_pct = 17;
        test_random_traffic(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(25);

        s_tvalid <= 1'b0;
        while (expected_pools.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d loads and %0d queries over %0d register writes",
                 loads_sent, queries_sent, reg_writes);
        $display("Checked %0d pooled results, %0d of them empty windows",
                 results_seen, empty_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
